// ===== rtl/msec_pkg.sv =====
// ----------------------------------------------------------------------------
// msec_pkg
// types and constants shared by the execute core modules
// ----------------------------------------------------------------------------
package msec_pkg;

    localparam logic [31:0] RESET_PC     = 32'hbfc0_0000;
    localparam logic [31:0] REG_GARBAGE  = 32'hdead_beef;
    localparam logic [31:0] SEG_MASK     = 32'hf000_0000;
    localparam int unsigned ISOLATE_BIT  = 16;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL      = 6'b000000;
    localparam logic [5:0] OP_J            = 6'b000010;
    localparam logic [5:0] OP_JAL          = 6'b000011;
    localparam logic [5:0] OP_BNE          = 6'b000101;
    localparam logic [5:0] OP_ADDI         = 6'b001000;
    localparam logic [5:0] OP_ADDI_NOTRAP  = 6'b001001;
    localparam logic [5:0] OP_ANDI         = 6'b001100;
    localparam logic [5:0] OP_ORI          = 6'b001101;
    localparam logic [5:0] OP_LUI          = 6'b001111;
    localparam logic [5:0] OP_COP0         = 6'b010000;
    localparam logic [5:0] OP_LW           = 6'b100011;
    localparam logic [5:0] OP_SB           = 6'b101000;
    localparam logic [5:0] OP_SH           = 6'b101001;
    localparam logic [5:0] OP_SW           = 6'b101011;

    // special function codes
    localparam logic [5:0] FN_SLL  = 6'b000000;
    localparam logic [5:0] FN_JR   = 6'b001000;
    localparam logic [5:0] FN_ADDU = 6'b100001;
    localparam logic [5:0] FN_OR   = 6'b100101;
    localparam logic [5:0] FN_SLTU = 6'b101011;

    // cop0 move-to selector in the rs field
    localparam logic [4:0] COP0_MT = 5'b00100;

    // cop0 registers
    localparam logic [4:0] C0_BPC      = 5'd3;
    localparam logic [4:0] C0_BDA      = 5'd5;
    localparam logic [4:0] C0_JUMPDEST = 5'd6;
    localparam logic [4:0] C0_DCIC     = 5'd7;
    localparam logic [4:0] C0_BDAM     = 5'd9;
    localparam logic [4:0] C0_BPCM     = 5'd11;
    localparam logic [4:0] C0_SR       = 5'd12;
    localparam logic [4:0] C0_CAUSE    = 5'd13;

    localparam logic [4:0] LINK_REG = 5'd31;

    // memory request codes
    localparam logic [2:0] MOP_NONE = 3'd0;
    localparam logic [2:0] MOP_LW   = 3'd1;
    localparam logic [2:0] MOP_SB   = 3'd2;
    localparam logic [2:0] MOP_SH   = 3'd3;
    localparam logic [2:0] MOP_SW   = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW = 3'd2;
    localparam logic [2:0] ERR_C0_VALUE = 3'd3;
    localparam logic [2:0] ERR_C0_REG   = 3'd4;

    // one register file write
    typedef struct packed {
        logic        we;
        logic [4:0]  idx;
        logic [31:0] data;
    } t_rf_wr;

    // everything one instruction produces
    typedef struct packed {
        logic        wr_en;
        logic [4:0]  wr_idx;
        logic [31:0] wr_data;
        logic [31:0] npc;
        logic [2:0]  mop;
        logic [31:0] maddr;
        logic [31:0] sdata;
        logic [2:0]  err;
        logic [31:0] nsr;
        logic [4:0]  ld_idx;
    } t_exec_res;

endpackage

// ===== rtl/msec_regfile.sv =====
// ----------------------------------------------------------------------------
// msec_regfile
// general registers: two banks with a latest-bank flag, registered reads
// ----------------------------------------------------------------------------
module msec_regfile
    import msec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_rd_a_idx,   // operand addresses for the next step
    input  logic [4:0]  i_rd_b_idx,
    input  logic [4:0]  i_use_a_idx,  // operand addresses of the current step
    input  logic [4:0]  i_use_b_idx,
    input  t_rf_wr      i_ex_wr,      // instruction write, wins over load
    input  t_rf_wr      i_ld_wr,      // load data write
    output logic [31:0] o_a,
    output logic [31:0] o_b
);

    logic [31:0] r_bank_ex [32];
    logic [31:0] r_bank_ld [32];
    logic [31:0] r_q_ex_a, r_q_ex_b, r_q_ld_a, r_q_ld_b;
    logic [31:0] r_valid;
    logic [31:0] r_sel_ld;
    t_rf_wr      r_byp_ex, r_byp_ld;

    // banks: one write and two registered reads each
    always_ff @(posedge i_clk) begin
        if (i_ex_wr.we) begin
            r_bank_ex[i_ex_wr.idx] <= i_ex_wr.data;
        end
        if (i_ld_wr.we) begin
            r_bank_ld[i_ld_wr.idx] <= i_ld_wr.data;
        end
        r_q_ex_a <= r_bank_ex[i_rd_a_idx];
        r_q_ex_b <= r_bank_ex[i_rd_b_idx];
        r_q_ld_a <= r_bank_ld[i_rd_a_idx];
        r_q_ld_b <= r_bank_ld[i_rd_b_idx];
    end

    // valid and latest-bank flags, plus the writes made at the last edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_sel_ld    <= '0;
            r_byp_ex.we <= 1'b0;
            r_byp_ld.we <= 1'b0;
        end else begin
            if (i_ld_wr.we) begin
                r_valid[i_ld_wr.idx]  <= 1'b1;
                r_sel_ld[i_ld_wr.idx] <= 1'b1;
            end
            if (i_ex_wr.we) begin
                r_valid[i_ex_wr.idx]  <= 1'b1;
                r_sel_ld[i_ex_wr.idx] <= 1'b0;
            end
            r_byp_ex.we <= i_ex_wr.we;
            r_byp_ld.we <= i_ld_wr.we;
        end
        r_byp_ex.idx  <= i_ex_wr.idx;
        r_byp_ex.data <= i_ex_wr.data;
        r_byp_ld.idx  <= i_ld_wr.idx;
        r_byp_ld.data <= i_ld_wr.data;
    end

    function automatic logic [31:0] f_operand(
        input logic [4:0]  idx,
        input logic [31:0] q_ex,
        input logic [31:0] q_ld,
        input logic [31:0] valid,
        input logic [31:0] sel_ld,
        input t_rf_wr      byp_ex,
        input t_rf_wr      byp_ld
    );
        logic [31:0] val;
        priority if (idx == 5'd0) begin
            val = '0;
        end else if (byp_ex.we && byp_ex.idx == idx) begin
            val = byp_ex.data;
        end else if (byp_ld.we && byp_ld.idx == idx) begin
            val = byp_ld.data;
        end else if (!valid[idx]) begin
            val = REG_GARBAGE;
        end else if (sel_ld[idx]) begin
            val = q_ld;
        end else begin
            val = q_ex;
        end
        return val;
    endfunction

    assign o_a = f_operand(i_use_a_idx, r_q_ex_a, r_q_ld_a, r_valid, r_sel_ld,
                           r_byp_ex, r_byp_ld);
    assign o_b = f_operand(i_use_b_idx, r_q_ex_b, r_q_ld_b, r_valid, r_sel_ld,
                           r_byp_ex, r_byp_ld);

endmodule

// ===== rtl/msec_exec.sv =====
// ----------------------------------------------------------------------------
// msec_exec
// decode and execute of one instruction
// ----------------------------------------------------------------------------
module msec_exec
    import msec_pkg::*;
(
    input  logic [31:0] i_instr,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_status,
    output t_exec_res   o_res
);

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [31:0] imm, simm, pc4, sum, jtarget;
    logic        isolated;

    assign op       = i_instr[31:26];
    assign rs       = i_instr[25:21];
    assign rt       = i_instr[20:16];
    assign rd       = i_instr[15:11];
    assign sa       = i_instr[10:6];
    assign fn       = i_instr[5:0];
    assign imm      = {16'd0, i_instr[15:0]};
    assign simm     = {{16{i_instr[15]}}, i_instr[15:0]};
    assign pc4      = i_pc + 32'd4;
    assign sum      = i_a + simm;
    assign jtarget  = (pc4 & SEG_MASK) | {4'd0, i_instr[25:0], 2'b00};
    assign isolated = i_status[ISOLATE_BIT];

    always_comb begin
        o_res         = '0;
        o_res.npc     = pc4;
        o_res.nsr     = i_status;
        o_res.wr_idx  = rt;
        unique case (op)
            OP_SPECIAL: begin
                o_res.wr_idx = rd;
                unique case (fn)
                    FN_SLL: begin
                        o_res.wr_en   = 1'b1;
                        o_res.wr_data = i_b << sa;
                    end
                    FN_OR: begin
                        o_res.wr_en   = 1'b1;
                        o_res.wr_data = i_a | i_b;
                    end
                    FN_SLTU: begin
                        o_res.wr_en   = 1'b1;
                        o_res.wr_data = {31'd0, i_a < i_b};
                    end
                    FN_ADDU: begin
                        o_res.wr_en   = 1'b1;
                        o_res.wr_data = i_a + i_b;
                    end
                    FN_JR: o_res.npc = i_a;
                    default: o_res.err = ERR_UNKNOWN;
                endcase
            end
            OP_LUI: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = {i_instr[15:0], 16'd0};
            end
            OP_ORI: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = i_a | imm;
            end
            OP_ANDI: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = i_a & imm;
            end
            OP_ADDI_NOTRAP: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_data = sum;
            end
            OP_ADDI: begin
                // signed overflow: both operands differ in sign from the sum
                if ((i_a[31] ^ sum[31]) & (simm[31] ^ sum[31])) begin
                    o_res.err = ERR_OVERFLOW;
                end else begin
                    o_res.wr_en   = 1'b1;
                    o_res.wr_data = sum;
                end
            end
            OP_SW, OP_SH, OP_SB: begin
                if (!isolated) begin
                    priority if (op == OP_SW) begin
                        o_res.mop = MOP_SW;
                    end else if (op == OP_SH) begin
                        o_res.mop = MOP_SH;
                    end else begin
                        o_res.mop = MOP_SB;
                    end
                    o_res.maddr = sum;
                    o_res.sdata = i_b;
                end
            end
            OP_LW: begin
                if (!isolated) begin
                    o_res.mop    = MOP_LW;
                    o_res.maddr  = sum;
                    o_res.ld_idx = rt;
                end
            end
            OP_J: o_res.npc = jtarget;
            OP_JAL: begin
                o_res.wr_en   = 1'b1;
                o_res.wr_idx  = LINK_REG;
                o_res.wr_data = pc4;
                o_res.npc     = jtarget;
            end
            OP_BNE: begin
                if (i_a != i_b) begin
                    o_res.npc = i_pc + {simm[29:0], 2'b00};
                end
            end
            OP_COP0: begin
                if (rs != COP0_MT) begin
                    o_res.err = ERR_UNKNOWN;
                end else begin
                    unique case (rd)
                        C0_BPC, C0_BDA, C0_JUMPDEST, C0_DCIC, C0_BDAM, C0_BPCM,
                        C0_CAUSE: begin
                            if (i_b != 32'd0) begin
                                o_res.err = ERR_C0_VALUE;
                            end
                        end
                        C0_SR: o_res.nsr = i_b;
                        default: o_res.err = ERR_C0_REG;
                    endcase
                end
            end
            default: o_res.err = ERR_UNKNOWN;
        endcase
    end

endmodule

// ===== rtl/mips_subset_execute_core.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute_core
// executes a small mips subset with branch and load delay slots
// ----------------------------------------------------------------------------
//
// channel   direction  transaction
// s_axis    in         fetched word and load data for one step
// m_axis    out        next fetch address, memory request, error code
//
// one instruction per cycle: a transaction on s_axis executes the pending
// instruction against the architectural state and lands in the result
// register; a new transaction may follow every cycle
// the result register is the only stage, so s_axis is held off only while a
// result sits unclaimed on m_axis
// synchronous active-low reset puts the pc at the boot vector, the pending
// instruction to a no-op and marks every general register as unwritten
// after an error the core is halted: each transaction answers with the
// frozen pc and the sticky error code until reset
//
module mips_subset_execute_core
    import msec_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] fetched_word, [63:32] load_data
    input  logic [63:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] fetch_address, [34:32] mem_op, [66:35] mem_address,
    // [98:67] store_data, [101:99] error_code, [103:102] zero
    output logic [103:0] o_m_axis_tdata
);

    // architectural state
    logic [31:0]  r_pc, n_pc;
    logic [31:0]  r_instr, n_instr;
    logic [31:0]  r_status, n_status;
    logic [4:0]   r_ld_idx, n_ld_idx;
    logic [2:0]   r_halt, n_halt;

    // result register
    logic         r_out_valid;
    logic [101:0] r_out, n_out;

    logic [31:0]  fetched_word, load_data;
    logic [31:0]  op_a, op_b;
    logic         accept, running, commit;
    t_exec_res    ex;
    t_rf_wr       ex_wr, ld_wr;

    assign fetched_word = i_s_axis_tdata[31:0];
    assign load_data    = i_s_axis_tdata[63:32];

    // the result register frees itself as it is taken
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign running         = (r_halt == ERR_NONE);
    // a step that errs commits nothing, not even the pending load
    assign commit          = accept && running && (ex.err == ERR_NONE);

    msec_exec u_exec (
        .i_instr  (r_instr),
        .i_pc     (r_pc),
        .i_a      (op_a),
        .i_b      (op_b),
        .i_status (r_status),
        .o_res    (ex)
    );

    // register zero is never written; index zero means no load pending
    always_comb begin
        ex_wr.we   = commit && ex.wr_en && (ex.wr_idx != 5'd0);
        ex_wr.idx  = ex.wr_idx;
        ex_wr.data = ex.wr_data;
        ld_wr.we   = commit && (r_ld_idx != 5'd0);
        ld_wr.idx  = r_ld_idx;
        ld_wr.data = load_data;
    end

    // operands for the next step are read at the instruction about to become
    // pending; the register file forwards this edge's writes itself
    msec_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_a_idx  (n_instr[25:21]),
        .i_rd_b_idx  (n_instr[20:16]),
        .i_use_a_idx (r_instr[25:21]),
        .i_use_b_idx (r_instr[20:16]),
        .i_ex_wr     (ex_wr),
        .i_ld_wr     (ld_wr),
        .o_a         (op_a),
        .o_b         (op_b)
    );

    // state update
    always_comb begin
        n_pc     = r_pc;
        n_instr  = r_instr;
        n_status = r_status;
        n_ld_idx = r_ld_idx;
        n_halt   = r_halt;
        if (commit) begin
            n_pc     = ex.npc;
            n_instr  = fetched_word;
            n_status = ex.nsr;
            n_ld_idx = ex.ld_idx;
        end else if (accept && running) begin
            n_halt = ex.err;
        end
    end

    // result of this step; halted or failing steps report the frozen pc
    always_comb begin
        if (!running) begin
            n_out = {r_halt, 32'd0, 32'd0, MOP_NONE, r_pc};
        end else if (ex.err != ERR_NONE) begin
            n_out = {ex.err, 32'd0, 32'd0, MOP_NONE, r_pc};
        end else begin
            n_out = {ERR_NONE, ex.sdata, ex.maddr, ex.mop, ex.npc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= RESET_PC;
            r_instr     <= '0;
            r_status    <= '0;
            r_ld_idx    <= '0;
            r_halt      <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_instr  <= n_instr;
            r_status <= n_status;
            r_ld_idx <= n_ld_idx;
            r_halt   <= n_halt;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the mips subset execute core: a short directed
// program, then about 1900 random instructions that steer clear of faults,
// then one closing fault of a randomly chosen kind and a few halted steps;
// every result is checked against an in-bench model of the core
// ----------------------------------------------------------------------------
module tb_top
    import msec_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int DRAIN_CYCLES  = 20;

    // encodings the core must refuse, used only for the closing fault
    localparam logic [5:0] OP_UNUSED   = 6'b111111;
    localparam logic [5:0] FN_UNUSED   = 6'b000001;
    localparam logic [4:0] COP0_MF     = 5'b00000;
    localparam logic [4:0] C0_UNMAPPED = 5'd14;

    // architectural state of the core
    typedef struct packed {
        logic [2:0]        halt;
        logic [4:0]        ld_idx;
        logic [31:0]       sr;
        logic [31:0][31:0] gpr;
        logic [31:0]       pend;
        logic [31:0]       pc;
    } t_cpu;

    // one retired step, laid out as o_m_axis_tdata[101:0]
    typedef struct packed {
        logic [2:0]  err;
        logic [31:0] sdata;
        logic [31:0] maddr;
        logic [2:0]  mop;
        logic [31:0] fetch;
    } t_retire;

    logic          i_clk    = 1'b0;
    logic          i_rst_n  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [63:0]   s_tdata  = '0;   // [31:0] fetched_word, [63:32] load_data
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [103:0]  m_tdata;         // fetch, mem_op, mem_address, store_data, error_code

    logic [63:0]   fetch_q[$];      // words and load data still to be driven
    t_retire       retire_q[$];     // retirements owed by the core, oldest first
    t_cpu          gen_st;          // state seen by the program generator
    t_cpu          core_now;        // state of the core after the last accepted transaction

    int total_items = 0;
    int n_sent      = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_mem       = 0;
    int n_bad       = 0;
    int n_cycles    = 0;

    mips_subset_execute_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // core model
    // ------------------------------------------------------------------

    function automatic t_cpu boot_state();
        t_cpu st;
        st.pc     = RESET_PC;
        st.pend   = '0;
        for (int i = 0; i < 32; i++) st.gpr[i] = REG_GARBAGE;
        st.gpr[0] = '0;
        st.sr     = '0;
        st.ld_idx = '0;
        st.halt   = ERR_NONE;
        return st;
    endfunction

    // executes the pending instruction, takes the new word as the next one
    function automatic t_retire cpu_step(input t_cpu cur, input logic [31:0] word,
                                         input logic [31:0] ldata, output t_cpu nxt);
        logic [31:0][31:0] nr;
        logic [31:0] ins, npc, nsr, a, b, r, simm, maddr, sdata;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, npli;
        logic [2:0]  err, mop;
        logic        iso;
        t_retire     res;

        nxt   = cur;
        ins   = cur.pend;
        npc   = cur.pc + 32'd4;
        nsr   = cur.sr;
        nr    = cur.gpr;
        // the load lands first so that the instruction's own write wins
        nr[cur.ld_idx] = ldata;
        op    = ins[31:26];
        rs    = ins[25:21];
        rt    = ins[20:16];
        rd    = ins[15:11];
        fn    = ins[5:0];
        simm  = {{16{ins[15]}}, ins[15:0]};
        a     = cur.gpr[rs];
        b     = cur.gpr[rt];
        iso   = cur.sr[ISOLATE_BIT];
        err   = ERR_NONE;
        mop   = MOP_NONE;
        maddr = '0;
        sdata = '0;
        npli  = '0;

        if (cur.halt != ERR_NONE) begin
            err = cur.halt;
        end else begin
            case (op)
                OP_SPECIAL: begin
                    case (fn)
                        FN_SLL:  nr[rd] = b << ins[10:6];
                        FN_OR:   nr[rd] = a | b;
                        FN_SLTU: nr[rd] = (a < b) ? 32'd1 : 32'd0;
                        FN_ADDU: nr[rd] = a + b;
                        FN_JR:   npc = a;
                        default: err = ERR_UNKNOWN;
                    endcase
                end
                OP_LUI:   nr[rt] = {ins[15:0], 16'h0000};
                OP_ORI:   nr[rt] = a | {16'h0000, ins[15:0]};
                OP_ANDI:  nr[rt] = a & {16'h0000, ins[15:0]};
                OP_ADDI_NOTRAP: nr[rt] = a + simm;
                OP_ADDI: begin
                    r = a + simm;
                    if (((a ^ r) & (simm ^ r)) >> 31) err = ERR_OVERFLOW;
                    else nr[rt] = r;
                end
                OP_SW, OP_SH, OP_SB: begin
                    if (!iso) begin
                        mop   = (op == OP_SW) ? MOP_SW : (op == OP_SH) ? MOP_SH : MOP_SB;
                        maddr = a + simm;
                        sdata = b;
                    end
                end
                OP_LW: begin
                    if (!iso) begin
                        mop   = MOP_LW;
                        maddr = a + simm;
                        npli  = rt;
                    end
                end
                OP_J:    npc = (npc & SEG_MASK) | {4'h0, ins[25:0], 2'b00};
                OP_JAL: begin
                    nr[LINK_REG] = npc;
                    npc = (npc & SEG_MASK) | {4'h0, ins[25:0], 2'b00};
                end
                OP_BNE: begin
                    if (a != b) npc = npc + (simm << 2) - 32'd4;
                end
                OP_COP0: begin
                    if (rs != COP0_MT) begin
                        err = ERR_UNKNOWN;
                    end else begin
                        case (rd)
                            C0_BPC, C0_BDA, C0_JUMPDEST, C0_DCIC, C0_BDAM, C0_BPCM,
                            C0_CAUSE: begin
                                if (b != 32'd0) err = ERR_C0_VALUE;
                            end
                            C0_SR:   nsr = b;
                            default: err = ERR_C0_REG;
                        endcase
                    end
                end
                default: err = ERR_UNKNOWN;
            endcase
        end

        if (err != ERR_NONE) begin
            // nothing commits, the fault sticks
            nxt.halt  = err;
            res.fetch = cur.pc;
            res.mop   = MOP_NONE;
            res.maddr = '0;
            res.sdata = '0;
            res.err   = err;
        end else begin
            nr[0]      = '0;
            nxt.gpr    = nr;
            nxt.pc     = npc;
            nxt.pend   = word;
            nxt.sr     = nsr;
            nxt.ld_idx = npli;
            res.fetch  = npc;
            res.mop    = mop;
            res.maddr  = maddr;
            res.sdata  = sdata;
            res.err    = ERR_NONE;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // program generation
    // ------------------------------------------------------------------

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [4:0] sa,
                                          input logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] enc_j(input logic [5:0] op, input logic [25:0] tgt);
        return {op, tgt};
    endfunction

    function automatic logic [31:0] enc_mtc0(input logic [4:0] rt, input logic [4:0] rd);
        return {OP_COP0, COP0_MT, rt, rd, 11'h000};
    endfunction

    // true when the word can go in without making the core fault
    function automatic bit fits(input logic [31:0] w, input logic [31:0] ld);
        t_cpu    trial, scratch;
        t_retire r;
        r = cpu_step(gen_st, w, ld, trial);
        if (r.err != ERR_NONE) return 1'b0;
        r = cpu_step(trial, 32'h0, 32'h0, scratch);
        return r.err == ERR_NONE;
    endfunction

    task automatic issue(input logic [31:0] w, input logic [31:0] ld);
        t_retire r;
        fetch_q.push_back({ld, w});
        r = cpu_step(gen_st, w, ld, gen_st);
    endtask

    // a faulting word is swapped for a no-op
    task automatic put(input logic [31:0] w);
        logic [31:0] ld;
        ld = $urandom();
        if (!fits(w, ld)) w = 32'h0;
        issue(w, ld);
    endtask

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h8000;
            3:       return 16'h7fff;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_instr();
        logic [4:0]  rs, rt, rd, sa, c0;
        logic [15:0] imm;
        logic [31:0] w;
        rs  = 5'($urandom_range(0, 31));
        rt  = 5'($urandom_range(0, 31));
        rd  = 5'($urandom_range(0, 31));
        sa  = 5'($urandom_range(0, 31));
        imm = pick_imm();
        case ($urandom_range(0, 17))
            0:  w = enc_i(OP_LUI, rs, rt, imm);
            1:  w = enc_i(OP_ORI, rs, rt, imm);
            2:  w = enc_i(OP_ANDI, rs, rt, imm);
            3:  w = enc_i(OP_ADDI_NOTRAP, rs, rt, imm);
            4:  w = enc_i(OP_ADDI, rs, rt, imm);
            5:  w = enc_i(OP_SW, rs, rt, imm);
            6:  w = enc_i(OP_LW, rs, rt, imm);
            7:  w = enc_i(OP_SH, rs, rt, imm);
            8:  w = enc_i(OP_SB, rs, rt, imm);
            9:  w = enc_j(OP_J, 26'($urandom()));
            10: w = enc_j(OP_JAL, 26'($urandom()));
            11: w = enc_i(OP_BNE, rs, rt, imm);
            12: begin
                case ($urandom_range(0, 7))
                    0:       c0 = C0_BPC;
                    1:       c0 = C0_BDA;
                    2:       c0 = C0_JUMPDEST;
                    3:       c0 = C0_DCIC;
                    4:       c0 = C0_BDAM;
                    5:       c0 = C0_BPCM;
                    6:       c0 = C0_CAUSE;
                    default: c0 = C0_SR;
                endcase
                // debug registers only take zero, so often write from r0
                if (c0 != C0_SR && $urandom_range(0, 1)) rt = 5'd0;
                w = enc_mtc0(rt, c0);
            end
            13: w = enc_r(rs, rt, rd, sa, FN_SLL);
            14: w = enc_r(rs, rt, rd, sa, FN_OR);
            15: w = enc_r(rs, rt, rd, sa, FN_SLTU);
            16: w = enc_r(rs, rt, rd, sa, FN_ADDU);
            default: w = enc_r(rs, rt, rd, sa, FN_JR);
        endcase
        return w;
    endfunction

    // sender and receiver hold-off per cent, by progress through the run
    function automatic int idle_pct(input bit sender);
        if (n_sent < total_items / 3)     return sender ? 34 : 69;
        if (n_sent < 2 * total_items / 3) return sender ? 69 : 34;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // driver: one transaction per handshake, model runs on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            core_now = boot_state();
        end else begin
            if (s_tvalid && s_tready) begin
                retire_q.push_back(cpu_step(core_now, s_tdata[31:0], s_tdata[63:32],
                                            core_now));
                n_accepted++;
            end
            // slot is free when nothing is offered or the offer was just taken
            if (!s_tvalid || s_tready) begin
                if (fetch_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                    s_tdata  <= fetch_q.pop_front();
                    s_tvalid <= 1'b1;
                    n_sent   <= n_sent + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each result transaction with the oldest retirement
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_retire got, want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[101:0];
                if (retire_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("[%0t] result with nothing owed: fetch %h mop %0d err %0d",
                                 $realtime, got.fetch, got.mop, got.err);
                end else begin
                    want = retire_q.pop_front();
                    n_checked++;
                    if (want.mop != MOP_NONE) n_mem++;
                    if (got.fetch != want.fetch || got.mop != want.mop ||
                        got.maddr != want.maddr || got.sdata != want.sdata ||
                        got.err != want.err) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $write("[%0t] result %0d mismatch: fetch %h/%h mop %0d/%0d ",
                                   $realtime, n_checked, want.fetch, got.fetch,
                                   want.mop, got.mop);
                            $display("maddr %h/%h sdata %h/%h err %0d/%0d (want/got)",
                                     want.maddr, got.maddr, want.sdata, got.sdata,
                                     want.err, got.err);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // program build, reset and end of run
    // ------------------------------------------------------------------
    initial begin : run
        int          n;
        int          sel;
        logic [4:0]  r;
        logic [31:0] w, ld;

        gen_st = boot_state();

        // directed program: each word runs one transaction after it is fetched
        put(enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000));          // r1 = 0x80000000
        put(enc_i(OP_ORI, 5'd1, 5'd1, 16'hffff));          // r1 = 0x8000ffff
        put(enc_i(OP_ADDI_NOTRAP, 5'd0, 5'd2, 16'hffff));  // r2 = all ones
        put(enc_i(OP_ANDI, 5'd2, 5'd3, 16'hffff));         // r3 = 0xffff
        put(enc_i(OP_ADDI, 5'd2, 5'd4, 16'h0001));         // wraps to zero, no signed overflow
        put(enc_r(5'd0, 5'd2, 5'd5, 5'd31, FN_SLL));       // widest shift
        put(enc_r(5'd1, 5'd3, 5'd6, 5'd0, FN_OR));
        put(enc_r(5'd3, 5'd2, 5'd7, 5'd0, FN_SLTU));       // unsigned compare against all ones
        put(enc_r(5'd2, 5'd2, 5'd8, 5'd0, FN_ADDU));
        put(enc_i(OP_SW, 5'd1, 5'd2, 16'h8000));           // most negative offset
        put(enc_i(OP_SH, 5'd0, 5'd1, 16'h7fff));           // most positive offset
        put(enc_i(OP_SB, 5'd2, 5'd3, 16'h0000));
        put(enc_i(OP_LW, 5'd0, 5'd9, 16'h0004));
        put(enc_r(5'd9, 5'd9, 5'd9, 5'd0, FN_ADDU));       // load delay: old r9, its write wins
        put(enc_i(OP_LW, 5'd3, 5'd0, 16'hfffc));           // load into r0 is dropped
        put(enc_i(OP_LW, 5'd0, 5'd10, 16'h0000));
        put(enc_r(5'd10, 5'd0, 5'd11, 5'd0, FN_OR));       // still sees the old r10
        put(enc_r(5'd10, 5'd0, 5'd12, 5'd0, FN_OR));       // now sees the loaded r10
        put(enc_mtc0(5'd0, C0_BPC));                       // debug register takes zero
        put(enc_i(OP_LUI, 5'd0, 5'd13, 16'h0001));
        put(enc_mtc0(5'd13, C0_SR));                       // isolate the cache
        put(enc_i(OP_LW, 5'd0, 5'd14, 16'h0000));          // suppressed, no load pending
        put(enc_i(OP_SW, 5'd0, 5'd2, 16'h0000));           // suppressed
        put(enc_mtc0(5'd0, C0_SR));
        put(enc_i(OP_BNE, 5'd1, 5'd2, 16'hfffe));          // taken backwards
        put(enc_i(OP_BNE, 5'd0, 5'd0, 16'h7fff));          // in the delay slot, not taken
        put(enc_j(OP_JAL, 26'h3ffffff));
        put(enc_r(5'd31, 5'd0, 5'd0, 5'd0, FN_JR));        // delay slot reads the new link
        put(enc_j(OP_J, 26'h0000000));

        // random part: mostly legal instructions, some noise and short idioms
        n = 0;
        while (n < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                // raw words, kept only when they do not fault
                do begin
                    w  = $urandom();
                    ld = $urandom();
                end while (!fits(w, ld));
                issue(w, ld);
                n++;
            end else if (sel < 22) begin
                // load then use, sometimes overwriting the loaded register
                r = 5'($urandom_range(1, 31));
                put(enc_i(OP_LW, 5'($urandom_range(0, 31)), r, pick_imm()));
                put(enc_r(r, 5'($urandom_range(0, 31)),
                          $urandom_range(0, 1) ? r : 5'($urandom_range(0, 31)), 5'd0,
                          FN_ADDU));
                n += 2;
            end else if (sel < 25) begin
                r = 5'($urandom_range(1, 31));
                put(enc_i(OP_LUI, 5'd0, r, 16'h0001));
                put(enc_mtc0(r, C0_SR));
                n += 2;
            end else if (sel < 29) begin
                put(enc_mtc0(5'd0, C0_SR));
                n++;
            end else begin
                do begin
                    w  = pick_instr();
                    ld = $urandom();
                end while (!fits(w, ld));
                issue(w, ld);
                n++;
            end
        end

        // closing fault, kind picked at random, then a few steps while halted
        case ($urandom_range(0, 5))
            0: issue(enc_i(OP_UNUSED, 5'd0, 5'd0, 16'h0000), $urandom());
            1: issue(enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_UNUSED), $urandom());
            2: issue({OP_COP0, COP0_MF, 5'd0, C0_SR, 11'h000}, $urandom());
            3: begin
                put(enc_i(OP_LUI, 5'd0, 5'd20, 16'h7fff));
                put(enc_i(OP_ORI, 5'd20, 5'd20, 16'hffff));
                issue(enc_i(OP_ADDI, 5'd20, 5'd21, 16'h0001), $urandom());
            end
            4: begin
                put(enc_i(OP_LUI, 5'd0, 5'd20, 16'h7fff));
                issue(enc_mtc0(5'd20, C0_DCIC), $urandom());
            end
            default: issue(enc_mtc0(5'd0, C0_UNMAPPED), $urandom());
        endcase
        repeat (6) issue($urandom(), $urandom());

        total_items = fetch_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (fetch_q.size() != 0 || s_tvalid || retire_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d instructions accepted, %0d results checked, %0d with memory requests",
                 n_accepted, n_checked, n_mem);
        $display("run: ended halted with code %0d, %0d mismatches", core_now.halt, n_bad);
        if (n_bad == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== mips_subset_execute_core.f =====
rtl/msec_pkg.sv
rtl/msec_regfile.sv
rtl/msec_exec.sv
rtl/mips_subset_execute_core.sv
tb/tb_top.sv
